FILE: rtl/ttc_pkg.sv
// ----------------------------------------------------------------------------
// ttc_pkg
// Shared types, codes and default constants for the tile threshold centroid.
// ----------------------------------------------------------------------------
package ttc_pkg;

	localparam int AREA_SIZE_DEF = 64;
	localparam int TILE_SIZE_DEF = 4;

	localparam logic [15:0] THRESHOLD_RST = 16'd2048;	// 8.0 in 8.8
	localparam logic [15:0] LIMIT_RST     = 16'hFFFF;

	// command codes
	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_MEASURE = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_NONE    = 2'd0;
	localparam logic [1:0] STAT_POINT   = 2'd1;
	localparam logic [1:0] STAT_LIMIT   = 2'd2;
	localparam logic [1:0] STAT_OUTSIDE = 2'd3;

	// configuration register indexes
	localparam logic [0:0] REG_THRESHOLD = 1'b0;
	localparam logic [0:0] REG_LIMIT     = 1'b1;

	typedef struct packed {
		logic [1:0]  command;
		logic [5:0]  pixel_col;
		logic [5:0]  pixel_row;
		logic [15:0] distance_value;
		logic [3:0]  tile_col;
		logic [3:0]  tile_row;
		logic [5:0]  area_col;
		logic [5:0]  area_row;
		logic [6:0]  area_width;
		logic [6:0]  area_height;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] point_x;
		logic [11:0] point_y;
		logic [15:0] point_index;
		logic [4:0]  match_count;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_CHECK,
		ST_DIV,
		ST_EMIT
	} state_t;

endpackage

FILE: rtl/tile_threshold_centroid.sv
// ----------------------------------------------------------------------------
// tile_threshold_centroid
// Per-tile centroid of pixels whose stored distance is below a threshold.
// ----------------------------------------------------------------------------
// Write and clear items are completed in the idle state. A measure item reads
// the tile's TILE_SIZE*TILE_SIZE distances one per cycle through the single
// read port of the store, then, after a flush and a check, runs two restoring
// dividers (x and y) before the result is emitted. A measure with no match or
// at the point limit skips the dividers. A tile outside the area skips the
// scan and goes straight to the result.
// The output register holds a finished result while the next item is taken.
// The store is not cleared at reset: tiles must be written before measuring.
module tile_threshold_centroid #(
	parameter int AREA_SIZE = ttc_pkg::AREA_SIZE_DEF,
	parameter int TILE_SIZE = ttc_pkg::TILE_SIZE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ttc_pkg::in_item_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output ttc_pkg::out_item_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [0:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	localparam int DEPTH = AREA_SIZE * AREA_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(AREA_SIZE);
	localparam int TW    = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
	localparam int SUM_W = $clog2(TILE_SIZE * TILE_SIZE * (AREA_SIZE - 1) + 1);
	localparam int CNT_W = $clog2(TILE_SIZE * TILE_SIZE + 1);
	localparam int EW    = 10;	// tile edge compare width
	localparam int PW    = 16;	// image coordinate before wrap

	ttc_pkg::state_t state_q, state_d;

	logic [15:0] threshold_q;
	logic [15:0] limit_q;
	logic [15:0] point_count_q;

	logic          in_fire;
	logic          cmd_write;
	logic          cmd_measure;
	logic          cmd_clear;
	logic          wr_in_range;
	logic          mem_we;
	logic [AW-1:0] waddr;

	logic [EW-1:0] w_eff;
	logic [EW-1:0] h_eff;
	logic [EW-1:0] x_end;
	logic [EW-1:0] y_end;
	logic          outside;

	logic [CW-1:0] x0_q;
	logic [CW-1:0] y0_q;
	logic [5:0]    acol_q;
	logic [5:0]    arow_q;
	logic [TW-1:0] dx_q;
	logic [TW-1:0] dy_q;
	logic          dx_last;
	logic          dy_last;
	logic [CW-1:0] px;
	logic [CW-1:0] py;
	logic          rd_en;
	logic [AW-1:0] raddr;
	logic [15:0]   rdata;

	logic          rd_v_s1;
	logic [CW-1:0] px_s1;
	logic [CW-1:0] py_s1;

	logic [SUM_W-1:0] sx_q;
	logic [SUM_W-1:0] sy_q;
	logic [CNT_W-1:0] cnt_q;

	logic          limit_hit;
	logic          div_start;
	logic          done_x;
	logic          done_y;
	logic [CW-1:0] qx;
	logic [CW-1:0] qy;

	logic [1:0]  status_q;
	logic        emit_fire;
	logic [8:0]  cnt_ext;
	logic [4:0]  cnt_sat;
	logic [PW-1:0] img_x;
	logic [PW-1:0] img_y;

	ttc_pkg::out_item_t out_q;
	logic               out_valid_q;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= ttc_pkg::THRESHOLD_RST;
			limit_q     <= ttc_pkg::LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ttc_pkg::REG_THRESHOLD: threshold_q <= cfg_data;
				ttc_pkg::REG_LIMIT:     limit_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- input decode ----------------
	assign in_ready = (state_q == ttc_pkg::ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		cmd_write   = 1'b0;
		cmd_measure = 1'b0;
		cmd_clear   = 1'b0;
		unique case (in_data.command)
			ttc_pkg::CMD_WRITE:   cmd_write   = 1'b1;
			ttc_pkg::CMD_MEASURE: cmd_measure = 1'b1;
			ttc_pkg::CMD_CLEAR:   cmd_clear   = 1'b1;
			default: ;
		endcase
	end

	assign wr_in_range = (9'(in_data.pixel_col) < 9'(AREA_SIZE))
		&& (9'(in_data.pixel_row) < 9'(AREA_SIZE));
	assign mem_we = in_fire && cmd_write && wr_in_range;
	assign waddr  = AW'(AW'(in_data.pixel_row) * AW'(AREA_SIZE)) + AW'(in_data.pixel_col);

	// area size above the store size counts as the store size
	assign w_eff = (EW'(in_data.area_width) > EW'(AREA_SIZE))
		? EW'(AREA_SIZE) : EW'(in_data.area_width);
	assign h_eff = (EW'(in_data.area_height) > EW'(AREA_SIZE))
		? EW'(AREA_SIZE) : EW'(in_data.area_height);
	assign x_end = EW'(EW'(in_data.tile_col) * EW'(TILE_SIZE)) + EW'(TILE_SIZE);
	assign y_end = EW'(EW'(in_data.tile_row) * EW'(TILE_SIZE)) + EW'(TILE_SIZE);
	assign outside = (x_end > w_eff) || (y_end > h_eff);

	// ---------------- scan ----------------
	assign dx_last = (dx_q == TW'(TILE_SIZE - 1));
	assign dy_last = (dy_q == TW'(TILE_SIZE - 1));
	assign px      = x0_q + CW'(dx_q);
	assign py      = y0_q + CW'(dy_q);
	assign raddr   = AW'(AW'(py) * AW'(AREA_SIZE)) + AW'(px);

	ttc_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (in_data.distance_value),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	ttc_div #(
		.NW (SUM_W),
		.DW (CNT_W),
		.QW (CW)
	) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sx_q),
		.divisor  (cnt_q),
		.done     (done_x),
		.quotient (qx)
	);

	ttc_div #(
		.NW (SUM_W),
		.DW (CNT_W),
		.QW (CW)
	) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sy_q),
		.divisor  (cnt_q),
		.done     (done_y),
		.quotient (qy)
	);

	assign limit_hit = (point_count_q >= limit_q);
	assign emit_fire = (state_q == ttc_pkg::ST_EMIT) && (!out_valid_q || out_ready);

	// ---------------- control ----------------
	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ttc_pkg::ST_IDLE: begin
				if (in_fire && cmd_measure) begin
					state_d = outside ? ttc_pkg::ST_EMIT : ttc_pkg::ST_SCAN;
				end
			end
			ttc_pkg::ST_SCAN: begin
				rd_en = 1'b1;
				if (dx_last && dy_last) begin
					state_d = ttc_pkg::ST_FLUSH;
				end
			end
			ttc_pkg::ST_FLUSH: begin
				state_d = ttc_pkg::ST_CHECK;
			end
			ttc_pkg::ST_CHECK: begin
				if (limit_hit || cnt_q == '0) begin
					state_d = ttc_pkg::ST_EMIT;
				end else begin
					div_start = 1'b1;
					state_d   = ttc_pkg::ST_DIV;
				end
			end
			ttc_pkg::ST_DIV: begin
				if (done_x && done_y) begin
					state_d = ttc_pkg::ST_EMIT;
				end
			end
			ttc_pkg::ST_EMIT: begin
				if (emit_fire) begin
					state_d = ttc_pkg::ST_IDLE;
				end
			end
			default: state_d = ttc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// tile setup and scan counters
	always_ff @(posedge clk) begin
		if (in_fire && cmd_measure) begin
			x0_q   <= CW'(in_data.tile_col * TILE_SIZE);
			y0_q   <= CW'(in_data.tile_row * TILE_SIZE);
			acol_q <= in_data.area_col;
			arow_q <= in_data.area_row;
			dx_q   <= '0;
			dy_q   <= '0;
		end else if (rd_en) begin
			if (dx_last) begin
				dx_q <= '0;
				dy_q <= dy_q + 1'b1;
			end else begin
				dx_q <= dx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= px;
		py_s1 <= py;
	end

	// sums of matching coordinates
	always_ff @(posedge clk) begin
		if (in_fire && cmd_measure) begin
			sx_q  <= '0;
			sy_q  <= '0;
			cnt_q <= '0;
		end else if (rd_v_s1 && rdata < threshold_q) begin
			sx_q  <= sx_q + SUM_W'(px_s1);
			sy_q  <= sy_q + SUM_W'(py_s1);
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && cmd_measure) begin
			status_q <= outside ? ttc_pkg::STAT_OUTSIDE : ttc_pkg::STAT_NONE;
		end else if (state_q == ttc_pkg::ST_CHECK) begin
			if (limit_hit) begin
				status_q <= ttc_pkg::STAT_LIMIT;
			end else if (cnt_q == '0) begin
				status_q <= ttc_pkg::STAT_NONE;
			end else begin
				status_q <= ttc_pkg::STAT_POINT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
		end else if (in_fire && cmd_clear) begin
			point_count_q <= '0;
		end else if (emit_fire && status_q == ttc_pkg::STAT_POINT) begin
			point_count_q <= point_count_q + 16'd1;
		end
	end

	// ---------------- result ----------------
	assign cnt_ext = 9'(cnt_q);
	assign cnt_sat = (cnt_ext > 9'd31) ? 5'd31 : cnt_ext[4:0];
	assign img_x   = PW'(PW'(acol_q) * PW'(AREA_SIZE)) + PW'(qx);
	assign img_y   = PW'(PW'(arow_q) * PW'(AREA_SIZE)) + PW'(qy);

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_q.status <= status_q;
			if (status_q == ttc_pkg::STAT_POINT) begin
				out_q.point_x     <= img_x[11:0];
				out_q.point_y     <= img_y[11:0];
				out_q.point_index <= point_count_q;
			end else begin
				out_q.point_x     <= '0;
				out_q.point_y     <= '0;
				out_q.point_index <= '0;
			end
			if (status_q == ttc_pkg::STAT_POINT || status_q == ttc_pkg::STAT_LIMIT) begin
				out_q.match_count <= cnt_sat;
			end else begin
				out_q.match_count <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ---------------- assertions ----------------
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && status_q == ttc_pkg::STAT_POINT)
		|=> point_count_q == $past(point_count_q) + 16'd1)
		else $error("point count did not advance on a stored point");

	a_inside_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && cmd_measure && !outside) |=> state_q == ttc_pkg::ST_SCAN)
		else $error("measure inside the area did not start a scan");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ttc_pkg::ST_CHECK) |-> cnt_q <= CNT_W'(TILE_SIZE * TILE_SIZE))
		else $error("match count exceeds tile pixel count");

	a_point_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == ttc_pkg::STAT_POINT) |-> out_data.match_count != 5'd0)
		else $error("stored point with no matching pixel");

endmodule

FILE: rtl/ttc_store.sv
// ----------------------------------------------------------------------------
// ttc_store
// Distance store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ttc_store #(
	parameter int DEPTH = ttc_pkg::AREA_SIZE_DEF * ttc_pkg::AREA_SIZE_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/ttc_div.sv
// ----------------------------------------------------------------------------
// ttc_div
// Restoring divider, one quotient bit per cycle, MSB first.
// Quotient is known to fit in QW bits.
// ----------------------------------------------------------------------------
module ttc_div #(
	parameter int NW = 16,	// dividend width
	parameter int DW = 5,	// divisor width
	parameter int QW = 6	// quotient width
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [QW-1:0] quotient
);

	localparam int BW = (QW > 1) ? $clog2(QW) : 1;
	localparam int XW = NW + QW;

	logic          busy_q;
	logic          done_q;
	logic [BW-1:0] bit_q;
	logic [NW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] quo_q;
	logic [XW-1:0] trial;
	logic          fits;

	assign trial = XW'(den_q) << bit_q;
	assign fits  = XW'(rem_q) >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && bit_q == '0) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			den_q <= divisor;
			bit_q <= BW'(QW - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - trial[NW-1:0];
			end
			quo_q <= {quo_q[QW-2:0], fits};
			bit_q <= bit_q - 1'b1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
